// ===== sv/atan2cv_pkg.sv =====
package atan2cv_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int ITERATIONS_DEF  = 11;

   // angle accumulator, half turn = 0x10000, sum of all terms stays well inside
   localparam int ACC_W       = 17;
   localparam int ANGLE_W     = 15;
   localparam int OCT_W       = 3;
   localparam int TERM_W      = 16;
   localparam int SCALE_LIMIT = 32'h0001_0000;
   localparam int SCALE_SHIFT = 12;

   // octant code that stands for half a turn (4 eighth turns)
   localparam logic [OCT_W-1:0] OCT_HALF_TURN = 3'd4;
   localparam logic [OCT_W-1:0] OCT_ZERO      = 3'd0;

   // atan(2^-i), half turn = 0x10000, i = 0..15
   localparam logic [TERM_W-1:0] ARC_TERMS [16] = '{
      16'h4000, 16'h25C8, 16'h13F6, 16'h0A22, 16'h0516, 16'h028C, 16'h0146, 16'h00A3,
      16'h0051, 16'h0029, 16'h0014, 16'h000A, 16'h0005, 16'h0003, 16'h0001, 16'h0001
   };

   typedef struct packed {
      logic             valid;
      logic             bypass;
      logic [OCT_W-1:0] octant;
   } ctl_type;

endpackage

// ===== sv/atan2cv_fold.sv =====
module atan2cv_fold #(
   parameter int COORD_WIDTH = 16,
   parameter int DATA_W      = 31
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic signed [COORD_WIDTH-1:0] in_x,
   input  logic signed [COORD_WIDTH-1:0] in_y,
   output logic                          in_ready,
   output atan2cv_pkg::ctl_type          out_ctl,
   output logic signed [DATA_W-1:0]      out_x,
   output logic signed [DATA_W-1:0]      out_y,
   output logic signed [atan2cv_pkg::ACC_W-1:0] out_acc,
   input  logic                          out_ready
);
   import atan2cv_pkg::*;

   localparam int FW = COORD_WIDTH + 2;

   ctl_type                  ctl_ff, ctl_in;
   logic signed [DATA_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [FW-1:0]     x0, y0, x1, y1, x2, y2, x3, y3;
   logic signed [DATA_W-1:0] xe, ye;
   logic                     neg_y, swap, diag;

   always_comb begin
      x0 = FW'(in_x);
      y0 = FW'(in_y);
      neg_y = y0 < 0;
      x1 = neg_y ? -x0 : x0;
      y1 = neg_y ? -y0 : y0;
      swap = x1 <= 0;
      x2 = swap ? y1 : x1;
      y2 = swap ? -x1 : y1;
      diag = x2 <= y2;
      x3 = diag ? x2 + y2 : x2;
      y3 = diag ? y2 - x2 : y2;
      xe = DATA_W'(x3);
      ye = DATA_W'(y3);
      // small vectors are scaled up so the iterations keep precision
      if (xe < DATA_W'(SCALE_LIMIT)) begin
         x_in = xe <<< SCALE_SHIFT;
         y_in = ye <<< SCALE_SHIFT;
      end else begin
         x_in = xe;
         y_in = ye;
      end
      ctl_in.valid = in_valid;
      if (in_y == '0) begin
         ctl_in.bypass = 1'b1;
         ctl_in.octant = (in_x < 0) ? OCT_HALF_TURN : OCT_ZERO;
      end else begin
         ctl_in.bypass = 1'b0;
         ctl_in.octant = {neg_y, swap, diag};
      end
   end

   assign in_ready = !ctl_ff.valid || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (in_ready) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

   assign out_ctl = ctl_ff;
   assign out_x   = x_ff;
   assign out_y   = y_ff;
   assign out_acc = '0;
endmodule

// ===== sv/atan2cv_cell.sv =====
module atan2cv_cell #(
   parameter int STEP   = 1,
   parameter int DATA_W = 31
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  atan2cv_pkg::ctl_type                  in_ctl,
   input  logic signed [DATA_W-1:0]              in_x,
   input  logic signed [DATA_W-1:0]              in_y,
   input  logic signed [atan2cv_pkg::ACC_W-1:0]  in_acc,
   output logic                                  in_ready,
   output atan2cv_pkg::ctl_type                  out_ctl,
   output logic signed [DATA_W-1:0]              out_x,
   output logic signed [DATA_W-1:0]              out_y,
   output logic signed [atan2cv_pkg::ACC_W-1:0]  out_acc,
   input  logic                                  out_ready
);
   import atan2cv_pkg::*;

   localparam logic signed [ACC_W-1:0] TERM = ACC_W'({1'b0, ARC_TERMS[STEP]});

   ctl_type                  ctl_ff;
   logic signed [DATA_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [DATA_W-1:0] x_sh, y_sh;

   always_comb begin
      x_sh = in_x >>> STEP;
      y_sh = in_y >>> STEP;
      // rotate toward the x axis, direction from the sign of y
      if (in_y >= 0) begin
         x_in   = in_x + y_sh;
         y_in   = in_y - x_sh;
         acc_in = in_acc + TERM;
      end else begin
         x_in   = in_x - y_sh;
         y_in   = in_y + x_sh;
         acc_in = in_acc - TERM;
      end
   end

   assign in_ready = !ctl_ff.valid || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (in_ready) begin
         ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_ctl.valid) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         acc_ff <= acc_in;
      end
   end

   assign out_ctl = ctl_ff;
   assign out_x   = x_ff;
   assign out_y   = y_ff;
   assign out_acc = acc_ff;
endmodule

// ===== sv/atan2cv_sum.sv =====
module atan2cv_sum (
   input  logic                                  clock,
   input  logic                                  reset,
   input  atan2cv_pkg::ctl_type                  in_ctl,
   input  logic signed [atan2cv_pkg::ACC_W-1:0]  in_acc,
   output logic                                  in_ready,
   output logic                                  out_valid,
   output logic [atan2cv_pkg::ANGLE_W-1:0]       out_angle,
   input  logic                                  out_stall
);
   import atan2cv_pkg::*;

   logic                     valid_ff;
   logic [ANGLE_W-1:0]       angle_ff, angle_in, base;
   logic signed [ACC_W-1:0]  acc_sh;

   always_comb begin
      base   = {in_ctl.octant, {(ANGLE_W-OCT_W){1'b0}}};
      acc_sh = in_acc >>> 2;
      // wraps modulo a full turn
      angle_in = in_ctl.bypass ? base : base + acc_sh[ANGLE_W-1:0];
   end

   assign in_ready = !valid_ff || !out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_ctl.valid) begin
         angle_ff <= angle_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_angle = angle_ff;
endmodule

// ===== sv/atan2_cordic_vectoring_top.sv =====
// Angle of a signed (x, y) vector, 0x8000 per full turn, by CORDIC vectoring.
// A new coordinate pair is taken every cycle while req_stall is low; each
// result passes through one fold-and-scale stage, one cell per CORDIC
// iteration and one output stage, and waits while rsp_stall holds results
// back. Each stage moves on as soon as the stage after it has room, so
// bubbles close up behind a stalled output.
module atan2_cordic_vectoring_top #(
   parameter int ITERATIONS  = atan2cv_pkg::ITERATIONS_DEF,
   parameter int COORD_WIDTH = atan2cv_pkg::COORD_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [COORD_WIDTH-1:0]        req_x_coord,
   input  logic signed [COORD_WIDTH-1:0]        req_y_coord,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [atan2cv_pkg::ANGLE_W-1:0]      rsp_angle
);
   import atan2cv_pkg::*;

   // folded x reaches 2^COORD_WIDTH, scaled by 2^12, CORDIC gain below 2
   localparam int DATA_W = COORD_WIDTH + SCALE_SHIFT + 3;

   ctl_type                  ctl   [ITERATIONS+1];
   logic signed [DATA_W-1:0] xs    [ITERATIONS+1];
   logic signed [DATA_W-1:0] ys    [ITERATIONS+1];
   logic signed [ACC_W-1:0]  accs  [ITERATIONS+1];
   logic                     ready [ITERATIONS+2];

   atan2cv_fold #(
      .COORD_WIDTH (COORD_WIDTH),
      .DATA_W      (DATA_W)
   ) u_fold (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_x      (req_x_coord),
      .in_y      (req_y_coord),
      .in_ready  (ready[0]),
      .out_ctl   (ctl[0]),
      .out_x     (xs[0]),
      .out_y     (ys[0]),
      .out_acc   (accs[0]),
      .out_ready (ready[1])
   );

   assign req_stall = !ready[0];

   for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
      atan2cv_cell #(
         .STEP   (i + 1),
         .DATA_W (DATA_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_ctl    (ctl[i]),
         .in_x      (xs[i]),
         .in_y      (ys[i]),
         .in_acc    (accs[i]),
         .in_ready  (ready[i+1]),
         .out_ctl   (ctl[i+1]),
         .out_x     (xs[i+1]),
         .out_y     (ys[i+1]),
         .out_acc   (accs[i+1]),
         .out_ready (ready[i+2])
      );
   end

   atan2cv_sum u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (ctl[ITERATIONS]),
      .in_acc    (accs[ITERATIONS]),
      .in_ready  (ready[ITERATIONS+1]),
      .out_valid (rsp_valid),
      .out_angle (rsp_angle),
      .out_stall (rsp_stall)
   );
endmodule

// ===== tb/sv/atan2_cordic_vectoring_top_test.sv =====
`timescale 1ns / 100ps

module atan2_cordic_vectoring_top_test;

   import atan2cv_pkg::*;

   localparam int CW = COORD_WIDTH_DEF;
   localparam logic [ANGLE_W-1:0] ANGLE_HALF = 15'h4000;
   localparam logic [ANGLE_W-1:0] ANGLE_ZERO = 15'h0000;
   localparam longint EIGHTH_TURN = 64'h1000;
   localparam int RANDOM_ITEMS = 1530;
   localparam int PAUSE_AT = 1000;
   localparam int HOLD_AFTER = 600;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = ITERATIONS_DEF + 12;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic                 known;
      logic [ANGLE_W-1:0]   angle;
   } coord_row_type;

   // known = 1 rows carry the angle typed in, the rest go through the predictor
   localparam int DIR_ROWS = 22;
   localparam coord_row_type DIRECTED [DIR_ROWS] = '{
      '{16'h0000, 16'h0000, 1'b1, ANGLE_ZERO},   // zero vector
      '{16'h7FFF, 16'h0000, 1'b1, ANGLE_ZERO},
      '{16'h0001, 16'h0000, 1'b1, ANGLE_ZERO},
      '{16'hFFFF, 16'h0000, 1'b1, ANGLE_HALF},
      '{16'h8000, 16'h0000, 1'b1, ANGLE_HALF},
      '{16'h0000, 16'h7FFF, 1'b0, ANGLE_ZERO},
      '{16'h0000, 16'h8000, 1'b0, ANGLE_ZERO},
      '{16'h7FFF, 16'h7FFF, 1'b0, ANGLE_ZERO},
      '{16'h8000, 16'h8000, 1'b0, ANGLE_ZERO},   // folded x too big to scale
      '{16'h8000, 16'h7FFF, 1'b0, ANGLE_ZERO},
      '{16'h7FFF, 16'h8000, 1'b0, ANGLE_ZERO},
      '{16'h8000, 16'h0001, 1'b0, ANGLE_ZERO},
      '{16'h8000, 16'hFFFF, 1'b0, ANGLE_ZERO},
      '{16'h7FFF, 16'hFFFF, 1'b0, ANGLE_ZERO},   // wraps to just below a full turn
      '{16'h0064, 16'hFFFF, 1'b0, ANGLE_ZERO},
      '{16'h0001, 16'h0001, 1'b0, ANGLE_ZERO},
      '{16'hFFFF, 16'hFFFF, 1'b0, ANGLE_ZERO},
      '{16'h0001, 16'hFFFF, 1'b0, ANGLE_ZERO},
      '{16'hFFFF, 16'h0001, 1'b0, ANGLE_ZERO},
      '{16'h5555, 16'hAAAA, 1'b0, ANGLE_ZERO},
      '{16'hAAAA, 16'h5555, 1'b0, ANGLE_ZERO},
      '{16'h0FFF, 16'h0001, 1'b0, ANGLE_ZERO}
   };

   localparam logic signed [CW-1:0] EDGE_VALS [6] = '{
      16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic signed [CW-1:0] req_x_coord = '0;
   logic signed [CW-1:0] req_y_coord = '0;
   logic rsp_stall = 1'b0;
   logic req_stall;
   logic rsp_valid;
   logic [ANGLE_W-1:0] rsp_angle;

   logic [ANGLE_W-1:0] offered_angle = '0;
   logic [ANGLE_W-1:0] pending_angles [$];
   logic [ANGLE_W-1:0] expected_angle;
   int errors = 0;
   int results_seen = 0;

   atan2_cordic_vectoring_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_x_coord (req_x_coord),
      .req_y_coord (req_y_coord),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_angle   (rsp_angle)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [ANGLE_W-1:0] predict_angle(input logic signed [CW-1:0] xin,
                                                        input logic signed [CW-1:0] yin);
      longint x;
      longint y;
      longint t;
      longint acc;
      longint sum;
      int oct;
      int i;
      x = longint'(xin);
      y = longint'(yin);
      acc = 0;
      oct = 0;
      if (y == 0) begin
         return (x >= 0) ? ANGLE_ZERO : ANGLE_HALF;
      end
      // fold into the first octant
      if (y < 0) begin
         x = -x;
         y = -y;
         oct += 4;
      end
      if (x <= 0) begin
         t = x;
         x = y;
         y = -t;
         oct += 2;
      end
      if (x <= y) begin
         t = y - x;
         x = x + y;
         y = t;
         oct += 1;
      end
      if (x < SCALE_LIMIT) begin
         x = x <<< SCALE_SHIFT;
         y = y <<< SCALE_SHIFT;
      end
      for (i = 1; i <= ITERATIONS_DEF && i < 16; i++) begin
         if (y >= 0) begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            x = t;
            acc += longint'(ARC_TERMS[i]);
         end else begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            x = t;
            acc -= longint'(ARC_TERMS[i]);
         end
      end
      sum = oct * EIGHTH_TURN + (acc >>> 2);
      return sum[ANGLE_W-1:0];
   endfunction

   task automatic offer(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                        input logic [ANGLE_W-1:0] angle);
      req_valid <= 1'b1;
      req_x_coord <= x;
      req_y_coord <= y;
      offered_angle <= angle;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic pause_until_drained;
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_angles.size() != 0);
   endtask

   // scoreboard: expectation queued on each transfer in, checked on each transfer out
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            pending_angles.push_back(offered_angle);
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen <= results_seen + 1;
            if (pending_angles.size() == 0) begin
               $display("%0t: unexpected transfer out, expected none, actual angle %h",
                        $time, rsp_angle);
               errors++;
            end else begin
               expected_angle = pending_angles.pop_front();
               if (rsp_angle !== expected_angle) begin
                  $display("%0t: angle mismatch, expected %h, actual %h",
                           $time, expected_angle, rsp_angle);
                  errors++;
               end
            end
         end
      end
   end

   // receiver: stall pattern changes from segment to segment, one long hold-off
   initial begin : receiver
      int seg_len;
      int mode;
      int k;
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            for (k = 0; k < HOLD_CYCLES; k++) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end
         seg_len = $urandom_range(10, 80);
         mode = $urandom_range(0, 3);
         for (k = 0; k < seg_len; k++) begin
            case (mode)
               0: begin
                  rsp_stall <= 1'b0;
               end
               1: begin
                  rsp_stall <= ($urandom_range(0, 2) == 0);
               end
               2: begin
                  rsp_stall <= ((k % 5) < 2);
               end
               default: begin
                  rsp_stall <= 1'($urandom_range(0, 1));
               end
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin : sender
      logic signed [CW-1:0] vx;
      logic signed [CW-1:0] vy;
      int burst_left;
      int gap;
      int n;
      burst_left = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (n = 0; n < DIR_ROWS; n++) begin
         offer(DIRECTED[n].x, DIRECTED[n].y,
               DIRECTED[n].known ? DIRECTED[n].angle
                                 : predict_angle(DIRECTED[n].x, DIRECTED[n].y));
      end
      pause_until_drained();

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == PAUSE_AT) begin
            pause_until_drained();
         end else if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         if (burst_left > 0) begin
            burst_left--;
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               vx = CW'($urandom);
               vy = CW'($urandom);
            end
            5: begin
               vx = CW'($urandom_range(0, 16) - 8);
               vy = CW'($urandom_range(0, 16) - 8);
            end
            6: begin
               // on an axis
               vx = CW'($urandom);
               vy = '0;
               if ($urandom_range(0, 1)) begin
                  vy = vx;
                  vx = '0;
               end
            end
            7: begin
               // octant boundary, |x| == |y|
               vx = CW'($urandom);
               vy = $urandom_range(0, 1) ? vx : -vx;
            end
            8: begin
               vx = EDGE_VALS[$urandom_range(0, 5)];
               vy = EDGE_VALS[$urandom_range(0, 5)];
            end
            default: begin
               vx = CW'($urandom_range(0, 8192) - 4096);
               vy = CW'($urandom_range(0, 8192) - 4096);
            end
         endcase
         offer(vx, vy, predict_angle(vx, vy));
      end

      pause_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0 && pending_angles.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #5000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
